// ===== hdl/fpsf_pkg.sv =====
`timescale 1ns / 1ps

package fpsf_pkg;

  // byte lanes and register field widths
  localparam int DATA_W       = 8;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 16;
  localparam int CHAN_REG_W   = 3;

  // register port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [WIDTH_REG_W-1:0]  FRAME_WIDTH_RST   = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] FRAME_HEIGHT_RST  = 16'd480;
  localparam logic [CHAN_REG_W-1:0]   CHANNEL_COUNT_RST = 3'd3;

  // per-word control decided at the input side and carried down the pipeline
  typedef struct packed {
    logic take;      // sample enters the line stores and windows
    logic fire;      // word produces one result
    logic interior;  // result is a filtered value, else zero
    logic last;      // result closes the frame
  } fpsf_item_t;

endpackage

// ===== hdl/fpsf_line_mem.sv =====
`timescale 1ns / 1ps

module fpsf_line_mem import fpsf_pkg::*; #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // read old byte and write new one at the same column
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q        <= mem_q[addr_i];
      mem_q[addr_i]  <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/fpsf_ctrl.sv =====
`timescale 1ns / 1ps

module fpsf_ctrl import fpsf_pkg::*; #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_CHANNELS = 4,
  localparam int DEPTH  = MAX_WIDTH * MAX_CHANNELS,
  localparam int ADDR_W = $clog2(DEPTH),
  localparam int CH_W   = $clog2(MAX_CHANNELS + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [WIDTH_REG_W-1:0]  cfg_width_i,
  input  logic [HEIGHT_REG_W-1:0] cfg_height_i,
  input  logic [CHAN_REG_W-1:0]   cfg_chan_i,
  input  logic                    restart_i,
  input  logic                    acc_i,
  input  logic                    action_i,
  output logic [ADDR_W-1:0]       in_col_o,
  output logic [CH_W-1:0]         chan_o,
  output fpsf_item_t              item_o
);

  localparam int LEN_W  = $clog2(DEPTH + 1);
  localparam int CW     = LEN_W + 1;
  localparam int LEAD_W = $clog2(DEPTH + MAX_CHANNELS + 2);

  logic [LEN_W-1:0]        w_eff;
  logic [CH_W-1:0]         c_eff;
  logic [HEIGHT_REG_W-1:0] h_eff;
  logic [HEIGHT_REG_W-1:0] h_last;
  logic [LEN_W-1:0]        len;
  logic [LEAD_W-1:0]       thr;

  logic [ADDR_W-1:0]       in_col_q, in_col_d;
  logic [HEIGHT_REG_W-1:0] in_row_q, in_row_d;
  logic                    in_done_q, in_done_d;
  logic [ADDR_W-1:0]       out_col_q, out_col_d;
  logic [HEIGHT_REG_W-1:0] out_row_q, out_row_d;
  logic [LEAD_W-1:0]       lead_q, lead_d;

  logic              take;
  logic              in_done_n;
  logic [LEAD_W-1:0] lead_inc;
  logic              fire;
  logic              out_last;
  logic              interior;

  // effective frame geometry, out-of-range values clamped
  always_comb begin
    if (cfg_width_i == '0) begin
      w_eff = LEN_W'(1);
    end else if (32'(cfg_width_i) > MAX_WIDTH) begin
      w_eff = LEN_W'(MAX_WIDTH);
    end else begin
      w_eff = LEN_W'(cfg_width_i);
    end
    if (cfg_chan_i == '0) begin
      c_eff = CH_W'(1);
    end else if (32'(cfg_chan_i) > MAX_CHANNELS) begin
      c_eff = CH_W'(MAX_CHANNELS);
    end else begin
      c_eff = CH_W'(cfg_chan_i);
    end
    h_eff  = (cfg_height_i == '0) ? HEIGHT_REG_W'(1) : cfg_height_i;
    h_last = h_eff - HEIGHT_REG_W'(1);
    len    = w_eff * LEN_W'(c_eff);
    thr    = LEAD_W'(len) + LEAD_W'(c_eff) + LEAD_W'(1);
  end

  // result position checks
  assign out_last = (out_row_q == h_last) &&
                    ((CW'(out_col_q) + CW'(1)) == CW'(len));
  assign interior = (out_row_q != '0) && (out_row_q < h_last) &&
                    (CW'(out_col_q) >= CW'(c_eff)) &&
                    ((CW'(out_col_q) + CW'(c_eff)) < CW'(len));

  // position counters and release decision
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    in_done_n = in_done_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;

    take = acc_i && !action_i && !in_done_q;
    if (take) begin
      if ((CW'(in_col_q) + CW'(1)) == CW'(len)) begin
        in_col_d = '0;
        in_row_d = in_row_q + HEIGHT_REG_W'(1);
        if (in_row_q == h_last) begin
          in_done_n = 1'b1;
        end
      end else begin
        in_col_d = in_col_q + ADDR_W'(1);
      end
    end
    in_done_d = in_done_n;

    // results trail the input by one row plus one pixel
    lead_inc = lead_q + LEAD_W'(take);
    fire     = acc_i && (in_done_n || (lead_inc >= thr));
    lead_d   = lead_inc;

    if (fire) begin
      lead_d = lead_inc - LEAD_W'(1);
      if (out_last) begin
        in_col_d  = '0;
        in_row_d  = '0;
        in_done_d = 1'b0;
        out_col_d = '0;
        out_row_d = '0;
        lead_d    = '0;
      end else if ((CW'(out_col_q) + CW'(1)) == CW'(len)) begin
        out_col_d = '0;
        out_row_d = out_row_q + HEIGHT_REG_W'(1);
      end else begin
        out_col_d = out_col_q + ADDR_W'(1);
      end
    end

    if (restart_i) begin
      in_col_d  = '0;
      in_row_d  = '0;
      in_done_d = 1'b0;
      out_col_d = '0;
      out_row_d = '0;
      lead_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      in_done_q <= 1'b0;
      out_col_q <= '0;
      out_row_q <= '0;
      lead_q    <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      in_done_q <= in_done_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      lead_q    <= lead_d;
    end
  end

  assign in_col_o = in_col_q;
  assign chan_o   = c_eff;

  always_comb begin
    item_o.take     = take;
    item_o.fire     = fire;
    item_o.interior = interior;
    item_o.last     = out_last;
  end

  // output position never runs ahead of the release threshold
  a_lead_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lead_q < thr)
    else $error("lead counter reached release threshold");

  // a finished input frame always sits at column zero
  a_done_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_done_q |-> (in_col_q == '0))
    else $error("input column not cleared at frame end");

endmodule

// ===== hdl/fpsf_datapath.sv =====
`timescale 1ns / 1ps

module fpsf_datapath import fpsf_pkg::*; #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_CHANNELS = 4,
  localparam int DEPTH  = MAX_WIDTH * MAX_CHANNELS,
  localparam int ADDR_W = $clog2(DEPTH),
  localparam int CH_W   = $clog2(MAX_CHANNELS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              acc_i,
  input  fpsf_item_t        item_i,
  input  logic [ADDR_W-1:0] col_i,
  input  logic [DATA_W-1:0] sample_i,
  input  logic [CH_W-1:0]   chan_i,
  output logic              push_o,
  output logic [DATA_W-1:0] pixel_o,
  output logic              last_o,
  output logic [1:0]        pending_o
);

  localparam int IW0 = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int IW1 = $clog2(2 * MAX_CHANNELS);

  // 5*centre minus the four neighbours, clamped to a byte
  function automatic logic [DATA_W-1:0] sharpen(input logic [DATA_W-1:0] ctr,
                                                input logic [DATA_W-1:0] lft,
                                                input logic [DATA_W-1:0] rgt,
                                                input logic [DATA_W-1:0] abv,
                                                input logic [DATA_W-1:0] blw);
    logic [10:0] pos;
    logic [9:0]  neg;
    logic [10:0] diff;
    logic [DATA_W-1:0] res;
    pos  = 11'({ctr, 2'b00}) + 11'(ctr);
    neg  = 10'(lft) + 10'(rgt) + 10'(abv) + 10'(blw);
    diff = pos - 11'(neg);
    if (11'(neg) >= pos) begin
      res = '0;
    end else if (diff > 11'd255) begin
      res = 8'd255;
    end else begin
      res = diff[DATA_W-1:0];
    end
    return res;
  endfunction

  logic              v1_q, v2_q, v3_q;
  fpsf_item_t        ic1_q, ic2_q;
  logic [ADDR_W-1:0] col1_q;
  logic [DATA_W-1:0] smp1_q, smp2_q, a2_q;
  logic [DATA_W-1:0] a_rdata, b_rdata;

  logic [DATA_W-1:0] win0_q [MAX_CHANNELS];
  logic [DATA_W-1:0] win1_q [2*MAX_CHANNELS];
  logic [DATA_W-1:0] win2_q [MAX_CHANNELS];

  logic [IW0-1:0] sel_c;
  logic [IW1-1:0] sel_2c;

  logic [DATA_W-1:0] ctr3_q, lft3_q, rgt3_q, abv3_q, blw3_q;
  logic              int3_q, last3_q;

  // first line store: delays the stream by one row
  fpsf_line_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_line_a (
    .clk_i   (clk_i),
    .en_i    (acc_i && item_i.take),
    .addr_i  (col_i),
    .wdata_i (sample_i),
    .rdata_o (a_rdata)
  );

  // second line store: delays the row-old stream by one more row
  fpsf_line_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_line_b (
    .clk_i   (clk_i),
    .en_i    (v1_q && ic1_q.take),
    .addr_i  (col1_q),
    .wdata_i (a_rdata),
    .rdata_o (b_rdata)
  );

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= acc_i;
      v2_q <= v1_q;
      v3_q <= v2_q && ic2_q.fire;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    ic1_q  <= item_i;
    col1_q <= col_i;
    smp1_q <= sample_i;
    ic2_q  <= ic1_q;
    smp2_q <= smp1_q;
    a2_q   <= a_rdata;
  end

  // same-channel neighbour selects, c and 2c words back
  assign sel_c  = IW0'(chan_i - CH_W'(1));
  assign sel_2c = IW1'({chan_i, 1'b0} - (CH_W + 1)'(1));

  // operand capture from the windows before they shift
  always_ff @(posedge clk_i) begin
    ctr3_q  <= win1_q[sel_2c >> 1];
    lft3_q  <= win1_q[sel_2c];
    rgt3_q  <= a2_q;
    blw3_q  <= win0_q[sel_c];
    abv3_q  <= win2_q[sel_c];
    int3_q  <= ic2_q.interior;
    last3_q <= ic2_q.last;
  end

  // neighbour windows on the current, one-row-old and two-row-old streams
  always_ff @(posedge clk_i) begin
    if (v2_q && ic2_q.take) begin
      win0_q[0] <= smp2_q;
      win1_q[0] <= a2_q;
      win2_q[0] <= b_rdata;
      for (int j = 1; j < MAX_CHANNELS; j++) begin
        win0_q[j] <= win0_q[j-1];
        win2_q[j] <= win2_q[j-1];
      end
      for (int j = 1; j < 2 * MAX_CHANNELS; j++) begin
        win1_q[j] <= win1_q[j-1];
      end
    end
  end

  // result stage
  assign push_o  = v3_q;
  assign pixel_o = int3_q ? sharpen(ctr3_q, lft3_q, rgt3_q, abv3_q, blw3_q) : '0;
  assign last_o  = last3_q;

  assign pending_o = {1'b0, v1_q && ic1_q.fire} + {1'b0, v2_q && ic2_q.fire} +
                     {1'b0, v3_q};

endmodule

// ===== hdl/fpsf_out_fifo.sv =====
`timescale 1ns / 1ps

module fpsf_out_fifo import fpsf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] pixel_i,
  input  logic              last_i,
  input  logic [1:0]        pending_i,
  input  logic              ready_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] pixel_o,
  output logic              last_o,
  output logic              room_o
);

  localparam int FD    = 8;
  localparam int PTR_W = $clog2(FD);
  localparam int CNT_W = $clog2(FD + 1);

  logic [DATA_W:0]    entry_q [FD];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               pop;
  logic [CNT_W:0]     reserved;

  assign pop     = (count_q != '0) && ready_i;
  assign count_d = count_q + CNT_W'(push_i) - CNT_W'(pop);

  // result words in flight plus buffered must fit before a new word is taken
  assign reserved = (CNT_W + 1)'(count_q) + (CNT_W + 1)'(pending_i);
  assign room_o   = reserved < (CNT_W + 1)'(FD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= {last_i, pixel_i};
    end
  end

  assign valid_o = count_q != '0;
  assign {last_o, pixel_o} = entry_q[rd_ptr_q];

  // credit scheme keeps the buffer from overflowing
  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reserved <= (CNT_W + 1)'(FD))
    else $error("output buffer over-committed");

  // empty buffer has matching pointers
  a_empty_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (rd_ptr_q == wr_ptr_q))
    else $error("output buffer pointers out of step");

endmodule

// ===== hdl/five_point_sharpen_filter.sv =====
`timescale 1ns / 1ps

// Five-point sharpening filter on a raster stream of channel bytes (channels
// interleaved). Each sample becomes 5*centre minus its four same-channel
// neighbours, clamped to 0..255; first/last rows and pixel columns give 0.
// One word is taken per clock while s_axis_tready is high: tuser=0 carries
// a sample, tuser=1 is a drain tick. Results come out one row plus one
// pixel behind the input, so after the last sample of a frame that many
// drain ticks (or surplus words) flush the tail; tlast marks the final
// result. Each result goes through a three-stage pipeline (line store read,
// window select, arithmetic) into an 8-entry output buffer; s_axis_tready
// drops only when that buffer and the words in flight would fill it. The two
// line stores hold MAX_WIDTH*MAX_CHANNELS bytes each and need no clearing.
// Any register write restarts the frame and must be done while idle.

module five_point_sharpen_filter import fpsf_pkg::*; #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [DATA_W-1:0]     s_axis_tdata,   // [7:0] sample_value
  input  logic                  s_axis_tuser,   // [0] action
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [DATA_W-1:0]     m_axis_tdata,   // [7:0] pixel_value
  output logic                  m_axis_tlast
);

  localparam int DEPTH  = MAX_WIDTH * MAX_CHANNELS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CH_W   = $clog2(MAX_CHANNELS + 1);

  logic [WIDTH_REG_W-1:0]  cfg_width_q;
  logic [HEIGHT_REG_W-1:0] cfg_height_q;
  logic [CHAN_REG_W-1:0]   cfg_chan_q;
  logic [REG_IDX_W-1:0]    reg_idx;
  logic                    cfg_wr;
  logic                    restart;

  logic              acc;
  fpsf_item_t        item;
  logic [ADDR_W-1:0] in_col;
  logic [CH_W-1:0]   chan;
  logic              push;
  logic [DATA_W-1:0] push_pixel;
  logic              push_last;
  logic [1:0]        pending;
  logic              room;

  // register access
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (reg_idx)
      REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_CHANNEL_COUNT: restart = cfg_wr;
      default: restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= FRAME_WIDTH_RST;
      cfg_height_q <= FRAME_HEIGHT_RST;
      cfg_chan_q   <= CHANNEL_COUNT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FRAME_WIDTH:   cfg_width_q  <= pwdata[WIDTH_REG_W-1:0];
        REG_FRAME_HEIGHT:  cfg_height_q <= pwdata[HEIGHT_REG_W-1:0];
        REG_CHANNEL_COUNT: cfg_chan_q   <= pwdata[CHAN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRAME_WIDTH:   prdata = APB_DATA_W'(cfg_width_q);
      REG_FRAME_HEIGHT:  prdata = APB_DATA_W'(cfg_height_q);
      REG_CHANNEL_COUNT: prdata = APB_DATA_W'(cfg_chan_q);
      default:           prdata = '0;
    endcase
  end

  // input handshake
  assign s_axis_tready = room;
  assign acc           = s_axis_tvalid && s_axis_tready;

  fpsf_ctrl #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_width_i  (cfg_width_q),
    .cfg_height_i (cfg_height_q),
    .cfg_chan_i   (cfg_chan_q),
    .restart_i    (restart),
    .acc_i        (acc),
    .action_i     (s_axis_tuser),
    .in_col_o     (in_col),
    .chan_o       (chan),
    .item_o       (item)
  );

  fpsf_datapath #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .item_i    (item),
    .col_i     (in_col),
    .sample_i  (s_axis_tdata),
    .chan_i    (chan),
    .push_o    (push),
    .pixel_o   (push_pixel),
    .last_o    (push_last),
    .pending_o (pending)
  );

  fpsf_out_fifo u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .pixel_i   (push_pixel),
    .last_i    (push_last),
    .pending_i (pending),
    .ready_i   (m_axis_tready),
    .valid_o   (m_axis_tvalid),
    .pixel_o   (m_axis_tdata),
    .last_o    (m_axis_tlast),
    .room_o    (room)
  );

endmodule
